### design/tick_driven_multi_timer_core_macros.svh
// assertion macros shared by the timer core files
`ifndef TICK_DRIVEN_MULTI_TIMER_CORE_MACROS_SVH
`define TICK_DRIVEN_MULTI_TIMER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TDMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TDMT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TDMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDMT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

### design/tdmt_pkg.sv
package tdmt_pkg;
  localparam int unsigned NumChannels = 8;
  localparam int unsigned CountBits = 32;
  localparam int unsigned ChBits = 3;
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_INIT = 3'd1, OP_REMOVE = 3'd2, OP_PAUSE = 3'd3,
    OP_RESUME = 3'd4, OP_SET_PERIOD = 3'd5, OP_SET_CB = 3'd6, OP_READ = 3'd7
  } opcode_e;

  typedef struct packed {
    opcode_e     op;
    logic [2:0]  channel;
    logic [31:0] period;
    logic        repeat_req;
    logic        callback_on;
    logic [7:0]  accept_mask;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  period_mask;
    logic [7:0]  alarm_mask;
    logic [7:0]  fire_mask;
    logic [31:0] read_counter;
    logic [31:0] read_events;
    logic [31:0] read_callbacks;
    logic        read_running;
    logic        read_present;
    logic [31:0] base_ticks;
    logic [31:0] base_callbacks;
  } res_t;
endpackage

### design/tdmt_front.sv
// accepts and decodes items, zero period clamped, into a short command queue
module tdmt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [55:0]     in_data_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output tdmt_pkg::cmd_t  cmd_o
);
  import tdmt_pkg::*;
  `include "tick_driven_multi_timer_core_macros.svh"

  cmd_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.op          = opcode_e'(in_data_i[2:0]);
    dec.channel     = in_data_i[5:3];
    dec.period      = (in_data_i[37:6] == 32'd0) ? 32'd1 : in_data_i[37:6];
    dec.repeat_req  = in_data_i[38];
    dec.callback_on = in_data_i[39];
    dec.accept_mask = in_data_i[47:40];
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `TDMT_ASSERT(a_q_bound, clk_i, rst_ni, cnt_q <= 2'(QDepth), "queue overfilled")
  `TDMT_ASSERT(a_no_push_full, clk_i, rst_ni, (cnt_q == 2'(QDepth)) |-> !push,
    "push into full queue")
  `TDMT_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop |-> cnt_q != 2'd0, "pop from empty")
endmodule

### design/tdmt_back.sv
// executes commands; a tick walks channels one per cycle, but a running
// channel holds it while its modulo check runs as a restoring divider
module tdmt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  tdmt_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output tdmt_pkg::res_t  res_o
);
  import tdmt_pkg::*;
  `include "tick_driven_multi_timer_core_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_CHAN = 5'b00010, S_DIV = 5'b00100,
    S_UPD = 5'b01000, S_OUT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [NumChannels-1:0] pres_q, run_q, rep_q, cb_q;
  logic [31:0] per_q [NumChannels];
  logic [31:0] ctr_q [NumChannels];
  logic [31:0] evt_q [NumChannels];
  logic [31:0] cbc_q [NumChannels];
  logic [31:0] ticks_q, cbt_q;
  cmd_t        cmd_q;
  logic [2:0]  idx_q;
  logic [31:0] newc_q, rem_q, quo_q;
  logic [4:0]  bit_q;
  logic [7:0]  pm_q, am_q, fm_q;
  res_t        res_q, res_d;
  logic        rv_q;
  logic [32:0] trial;
  logic [31:0] cur_per;
  logic        zero_rem;

  assign cmd_ready_o = (state_q == S_IDLE) && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  assign cur_per     = per_q[idx_q];
  assign trial       = {rem_q, quo_q[31]};
  assign zero_rem    = (rem_q == 32'd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i && cmd_ready_o)
                state_d = (cmd_i.op == OP_TICK) ? S_CHAN : S_OUT;
      S_CHAN: if (pres_q[idx_q] && run_q[idx_q]) state_d = S_DIV;
              else if (idx_q == 3'(NumChannels-1)) state_d = S_OUT;
      S_DIV:  if (bit_q == 5'd31) state_d = S_UPD;
      S_UPD:  state_d = (idx_q == 3'(NumChannels-1)) ? S_OUT : S_CHAN;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = '0;
    res_d.period_mask    = pm_q;
    res_d.alarm_mask     = am_q;
    res_d.fire_mask      = fm_q;
    res_d.base_ticks     = ticks_q;
    res_d.base_callbacks = cbt_q;
    if (cmd_q.op == OP_READ) begin
      res_d.read_counter   = ctr_q[cmd_q.channel];
      res_d.read_events    = evt_q[cmd_q.channel];
      res_d.read_callbacks = cbc_q[cmd_q.channel];
      res_d.read_running   = run_q[cmd_q.channel];
      res_d.read_present   = pres_q[cmd_q.channel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rv_q <= 1'b0;
      pres_q <= '0; run_q <= '0; rep_q <= '0; cb_q <= '0;
      ticks_q <= '0; cbt_q <= '0; idx_q <= '0;
      cmd_q <= '0; newc_q <= '0; rem_q <= '0; quo_q <= '0; bit_q <= '0;
      pm_q <= '0; am_q <= '0; fm_q <= '0; res_q <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        per_q[i] <= 32'd1; ctr_q[i] <= '0; evt_q[i] <= '0; cbc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i && cmd_ready_o) begin
          cmd_q <= cmd_i; idx_q <= '0;
          pm_q <= '0; am_q <= '0; fm_q <= '0;
          if (cmd_i.op == OP_TICK) ticks_q <= ticks_q + 32'd1;
        end
        S_CHAN: begin
          if (pres_q[idx_q] && run_q[idx_q]) begin
            newc_q <= ctr_q[idx_q] + 32'd1;
            quo_q  <= ctr_q[idx_q] + 32'd1;
            rem_q  <= '0; bit_q <= '0;
          end else idx_q <= idx_q + 3'd1;
        end
        S_DIV: begin
          // restoring step: shift one dividend bit in, subtract if it fits
          if (trial >= {1'b0, cur_per}) rem_q <= 32'(trial - {1'b0, cur_per});
          else rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
          bit_q <= bit_q + 5'd1;
        end
        S_UPD: begin
          // a repeating channel restarts once its alarm fires
          ctr_q[idx_q] <= (zero_rem && (newc_q == cur_per) && rep_q[idx_q]) ? '0 : newc_q;
          if (zero_rem) begin
            evt_q[idx_q] <= evt_q[idx_q] + 32'd1;
            pm_q[idx_q] <= 1'b1;
            if (newc_q == cur_per) begin
              am_q[idx_q] <= 1'b1;
              if (cb_q[idx_q] && cmd_q.accept_mask[idx_q]) begin
                cbc_q[idx_q] <= cbc_q[idx_q] + 32'd1;
                cbt_q <= cbt_q + 32'd1;
                fm_q[idx_q] <= 1'b1;
              end
            end
          end
          idx_q <= idx_q + 3'd1;
        end
        S_OUT: begin
          rv_q <= 1'b1;
          res_q <= res_d;
          case (cmd_q.op)
            OP_INIT: begin
              pres_q[cmd_q.channel] <= 1'b1; run_q[cmd_q.channel] <= 1'b1;
              rep_q[cmd_q.channel] <= cmd_q.repeat_req;
              cb_q[cmd_q.channel] <= cmd_q.callback_on;
              per_q[cmd_q.channel] <= cmd_q.period;
              ctr_q[cmd_q.channel] <= '0; evt_q[cmd_q.channel] <= '0;
              cbc_q[cmd_q.channel] <= '0;
            end
            OP_REMOVE: begin
              pres_q[cmd_q.channel] <= 1'b0; run_q[cmd_q.channel] <= 1'b0;
              cb_q[cmd_q.channel] <= 1'b0;
              evt_q[cmd_q.channel] <= '0; cbc_q[cmd_q.channel] <= '0;
            end
            OP_PAUSE:  run_q[cmd_q.channel] <= 1'b0;
            OP_RESUME: run_q[cmd_q.channel] <= 1'b1;
            OP_SET_PERIOD: begin
              per_q[cmd_q.channel] <= cmd_q.period;
              ctr_q[cmd_q.channel] <= '0;
            end
            OP_SET_CB: begin
              cb_q[cmd_q.channel] <= cmd_q.callback_on;
              if (cmd_q.callback_on) ctr_q[cmd_q.channel] <= '0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  `TDMT_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `TDMT_ASSERT(a_out_valid, clk_i, rst_ni, (state_q == S_OUT) |=> rv_q,
    "result not raised")
  `TDMT_ASSERT(a_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !cmd_ready_o,
    "ready while busy")
endmodule

### design/tick_driven_multi_timer_core.sv
// Eight-channel tick-driven timer bank. Each item gives exactly one result.
// A non-tick operation passes from the idle state to the output state, which
// loads the result register. A tick walks all eight channels one per cycle,
// but each present and running channel holds the walk while a shared 32-step
// restoring divider tests its counter against the period, then an update state
// records the outcome. A two-entry command queue lets the input side accept
// while the executor works; results wait in an output register.
module tick_driven_multi_timer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], channel[5:3], period_ms[37:6], repeat_req[38],
  // callback_on[39], accept_mask[47:40], zero fill
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // period_mask[7:0], alarm_mask[15:8], fire_mask[23:16], read_counter[55:24],
  // read_events[87:56], read_callbacks[119:88], read_running[120],
  // read_present[121], base_ticks[153:122], base_callbacks[185:154], zero fill
  output logic [191:0] m_axis_tdata
);
  import tdmt_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  tdmt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tdmt_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.base_callbacks, res.base_ticks, res.read_present,
                         res.read_running, res.read_callbacks, res.read_events,
                         res.read_counter, res.fire_mask, res.alarm_mask,
                         res.period_mask};
endmodule

### verif/tb_tick_driven_multi_timer_core.sv
module tb_tick_driven_multi_timer_core;
  import tdmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;

  tick_driven_multi_timer_core DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [7:0]  pmask, amask, fmask;
    logic [31:0] rd_cnt, rd_evt, rd_cb;
    logic        rd_run, rd_pres;
    logic [31:0] ticks, cbs;
  } timer_res_t;

  typedef struct {
    opcode_e     op;
    logic [2:0]  ch;
    logic [31:0] per;
    logic        rep, cbon;
    logic [7:0]  acc;
    logic        has_exp;
    logic [31:0] exp_ticks;
  } stim_row_t;

  // timer bank shadow
  logic        sh_present [8];
  logic        sh_running [8];
  logic        sh_repeat [8];
  logic        sh_cb [8];
  logic [31:0] sh_period [8];
  logic [31:0] sh_counter [8];
  logic [31:0] sh_events [8];
  logic [31:0] sh_cbcount [8];
  logic [31:0] sh_ticks, sh_cbtotal;

  timer_res_t expected_q[$];
  int errors = 0;
  int sender_idle = 18, receiver_idle = 57;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic timer_res_t timer_step(stim_row_t s);
    timer_res_t r;
    logic [31:0] p;
    r = '0;
    p = (s.per == 0) ? 32'd1 : s.per;
    case (s.op)
      OP_TICK: begin
        sh_ticks = sh_ticks + 1;
        for (int i = 0; i < 8; i++) begin
          if (!sh_present[i] || !sh_running[i]) continue;
          sh_counter[i] = sh_counter[i] + 1;
          if (sh_counter[i] % sh_period[i] != 0) continue;
          sh_events[i] = sh_events[i] + 1;
          r.pmask[i] = 1'b1;
          if (sh_counter[i] != sh_period[i]) continue;
          r.amask[i] = 1'b1;
          if (sh_cb[i] && s.acc[i]) begin
            sh_cbcount[i] = sh_cbcount[i] + 1;
            sh_cbtotal = sh_cbtotal + 1;
            r.fmask[i] = 1'b1;
          end
          if (sh_repeat[i]) sh_counter[i] = '0;
        end
      end
      OP_INIT: begin
        sh_present[s.ch] = 1; sh_running[s.ch] = 1;
        sh_repeat[s.ch] = s.rep; sh_cb[s.ch] = s.cbon;
        sh_period[s.ch] = p; sh_counter[s.ch] = 0;
        sh_events[s.ch] = 0; sh_cbcount[s.ch] = 0;
      end
      OP_REMOVE: begin
        sh_present[s.ch] = 0; sh_running[s.ch] = 0; sh_cb[s.ch] = 0;
        sh_events[s.ch] = 0; sh_cbcount[s.ch] = 0;
      end
      OP_PAUSE: sh_running[s.ch] = 0;
      OP_RESUME: sh_running[s.ch] = 1;
      OP_SET_PERIOD: begin
        sh_period[s.ch] = p; sh_counter[s.ch] = 0;
      end
      OP_SET_CB: begin
        if (s.cbon) sh_counter[s.ch] = 0;
        sh_cb[s.ch] = s.cbon;
      end
      default: begin
        r.rd_cnt = sh_counter[s.ch]; r.rd_evt = sh_events[s.ch];
        r.rd_cb = sh_cbcount[s.ch]; r.rd_run = sh_running[s.ch];
        r.rd_pres = sh_present[s.ch];
      end
    endcase
    r.ticks = sh_ticks;
    r.cbs = sh_cbtotal;
    return r;
  endfunction

  // tvalid stays high between transactions unless the sender idles
  task automatic send_cmd(stim_row_t s);
    timer_res_t r;
    if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {8'd0, s.acc, s.cbon, s.rep, s.per, s.ch, s.op};
    do @(posedge clk_i); while (!s_axis_tready);
    r = timer_step(s);
    if (s.has_exp && r.ticks != s.exp_ticks) begin
      errors++;
      if (errors <= 10)
        $display("table row expects base_ticks %0d, model gives %0d", s.exp_ticks, r.ticks);
    end
    expected_q.push_back(r);
  endtask

  function automatic stim_row_t row(opcode_e op, int ch, logic [31:0] per,
                                    bit rep, bit cbon, logic [7:0] acc);
    stim_row_t s;
    s = '{op: op, ch: ch[2:0], per: per, rep: rep, cbon: cbon, acc: acc,
          has_exp: 1'b0, exp_ticks: '0};
    return s;
  endfunction

  // receiver side and result checking
  always @(posedge clk_i) begin
    timer_res_t e, a;
    if (m_axis_tvalid && m_axis_tready) begin
      a.pmask = m_axis_tdata[7:0]; a.amask = m_axis_tdata[15:8];
      a.fmask = m_axis_tdata[23:16]; a.rd_cnt = m_axis_tdata[55:24];
      a.rd_evt = m_axis_tdata[87:56]; a.rd_cb = m_axis_tdata[119:88];
      a.rd_run = m_axis_tdata[120]; a.rd_pres = m_axis_tdata[121];
      a.ticks = m_axis_tdata[153:122]; a.cbs = m_axis_tdata[185:154];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", m_axis_tdata);
      end else begin
        e = expected_q.pop_front();
        if (e != a) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp pm%h am%h fm%h c%h e%h cb%h r%b p%b t%h b%h",
                     e.pmask, e.amask, e.fmask, e.rd_cnt, e.rd_evt, e.rd_cb,
                     e.rd_run, e.rd_pres, e.ticks, e.cbs, "\n",
                     "         act pm%h am%h fm%h c%h e%h cb%h r%b p%b t%h b%h",
                     a.pmask, a.amask, a.fmask, a.rd_cnt, a.rd_evt, a.rd_cb,
                     a.rd_run, a.rd_pres, a.ticks, a.cbs);
        end
      end
    end
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= receiver_idle);
  end

  // long receiver stall so the command queue fills
  initial begin
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_off = 1'b0;
  end

  stim_row_t dir_tbl[$];
  stim_row_t s;
  int op_pick;

  initial begin
    for (int i = 0; i < 8; i++) begin
      sh_present[i] = 0; sh_running[i] = 0; sh_repeat[i] = 0; sh_cb[i] = 0;
      sh_period[i] = 1; sh_counter[i] = 0; sh_events[i] = 0; sh_cbcount[i] = 0;
    end
    sh_ticks = 0; sh_cbtotal = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    s = row(OP_READ, 0, 32'hFFFF_FFFF, 1, 1, 8'hFF); s.has_exp = 1; s.exp_ticks = 0;
    dir_tbl.push_back(s);
    s = row(OP_TICK, 7, 0, 0, 0, 8'h00); s.has_exp = 1; s.exp_ticks = 1;
    dir_tbl.push_back(s);
    dir_tbl.push_back(row(OP_INIT, 0, 0, 1, 1, 0));            // zero period
    dir_tbl.push_back(row(OP_INIT, 7, 32'hFFFF_FFFF, 0, 1, 0));
    dir_tbl.push_back(row(OP_INIT, 3, 2, 0, 1, 0));            // one-shot
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'hFF));
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'hFF));
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'h00));
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'hFF));
    dir_tbl.push_back(row(OP_READ, 3, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_PAUSE, 0, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'hFF));
    dir_tbl.push_back(row(OP_RESUME, 0, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_SET_PERIOD, 0, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_SET_CB, 0, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'hFF));
    dir_tbl.push_back(row(OP_SET_CB, 0, 0, 0, 1, 0));
    dir_tbl.push_back(row(OP_REMOVE, 7, 0, 0, 0, 0));
    // absent channel still takes resume and period writes
    dir_tbl.push_back(row(OP_RESUME, 7, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_SET_PERIOD, 5, 32'h8000_0000, 0, 0, 0));
    dir_tbl.push_back(row(OP_TICK, 0, 0, 0, 0, 8'hFF));
    dir_tbl.push_back(row(OP_READ, 7, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_READ, 5, 0, 0, 0, 0));
    dir_tbl.push_back(row(OP_READ, 0, 0, 0, 0, 0));
    foreach (dir_tbl[k]) send_cmd(dir_tbl[k]);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin sender_idle = 57; receiver_idle = 18; end
      if (ph == 2) begin sender_idle = 0; receiver_idle = 0; end
      for (int n = 0; n < 130; n++) begin
        op_pick = $urandom_range(99);
        s = row(OP_TICK, $urandom_range(7), 0, 1'($urandom_range(1)),
                1'($urandom_range(1)), 8'($urandom_range(255)));
        if (op_pick < 45) s.op = OP_TICK;
        else if (op_pick < 60) s.op = OP_INIT;
        else if (op_pick < 72) s.op = OP_READ;
        else s.op = opcode_e'($urandom_range(2, 6));
        // mostly short periods so alarms fire, sometimes wide values
        if ($urandom_range(9) == 0) s.per = $urandom;
        else s.per = $urandom_range(6);
        send_cmd(s);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("tb_tick_driven_multi_timer_core passed");
    else $display("tb_tick_driven_multi_timer_core failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_tick_driven_multi_timer_core failed");
    $finish;
  end
endmodule
